// ===== src/lg_pkg.sv =====
`default_nettype none
package lg_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_READ    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_RST_GEN = 3'd4
  } lg_cmd_t;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS    = 2'd0;
  localparam logic [1:0] CFG_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_RUNNING = 2'd2;

  // life rule
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_ADV
  } lg_state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] row;
    logic [5:0] column;
    logic       value;
  } lg_in_t;

  typedef struct packed {
    logic        cell_value;
    logic [31:0] generation;
    logic        applied;
  } lg_out_t;

  // neighbor information handed to one cell
  typedef struct packed {
    logic [1:0] left_sum;
    logic [1:0] right_sum;
    logic       in_use;
  } lg_nbr_t;

endpackage
`default_nettype wire

// ===== src/lg_ram.sv =====
`default_nettype none
module lg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/lg_cell.sv =====
`default_nettype none
module lg_cell
  import lg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic       bit_in,
  input  wire lg_nbr_t    nbr,
  output logic [1:0]      vsum,
  output logic            next_bit
);

  logic       top_r, mid_r, bot_r;
  logic [3:0] cnt;

  // advance the three-row window of this column
  always_ff @(posedge clk) begin
    if (shift_en) begin
      top_r <= mid_r;
      mid_r <= bot_r;
      bot_r <= bit_in;
    end
  end

  // column sum for the neighbors
  assign vsum = 2'({1'b0, top_r} + {1'b0, mid_r} + {1'b0, bot_r});

  always_comb begin
    cnt = 4'(nbr.left_sum) + 4'(nbr.right_sum) + 4'(top_r) + 4'(bot_r);
    if (!nbr.in_use) begin
      next_bit = mid_r;
    end else if (mid_r) begin
      next_bit = (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
    end else begin
      next_bit = (cnt == BIRTH_COUNT);
    end
  end

endmodule
`default_nettype wire

// ===== src/life_grid_generation_step.sv =====
`default_nettype none
// Toroidal life grid with a command channel.
// Issue a command by raising start with in_item while busy is low; the
// transaction is taken at that edge. Every command gives exactly one result:
// out_valid is high for one cycle with out_result, and the receiver cannot
// stall it. Write and read cell pass through a read-modify-write state;
// out-of-range or ignored commands and count reset answer straight from idle.
// Advance streams one grid row per cycle through a row of column cells (one
// cell per column, each passing its column sum to its neighbors). Clear
// writes one row per cycle.
// After reset the block runs the same clearing pass (busy high, no result);
// configuration writes on cfg_we/cfg_index/cfg_wdata are taken at any edge
// and should only be issued while idle.
module life_grid_generation_step
  import lg_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire lg_in_t     in_item,
  output logic            busy,
  output logic            out_valid,
  output lg_out_t         out_result,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_wdata
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int KW = $clog2(MAX_ROWS + 3);

  lg_state_t        state_r, state_nxt;
  logic [6:0]       rows_r, cols_r;
  logic             run_r;
  logic [31:0]      gen_r, gen_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             feed_v_r, feed_v_nxt;
  logic [KW-1:0]    feed_k_r, feed_k_nxt;
  logic             win_v_r, win_v_nxt;
  logic [KW-1:0]    win_k_r, win_k_nxt;
  logic [RW-1:0]    clr_r, clr_nxt;
  logic             clr_ack_r, clr_ack_nxt;
  lg_cmd_t          cmd_r, cmd_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             val_r, val_nxt;
  logic             out_valid_r, out_valid_nxt;
  lg_out_t          out_r, out_nxt;
  logic [MAX_COLUMNS-1:0] row0_r;

  logic [6:0]       nr, nc;
  logic [KW-1:0]    nr_k;
  logic [CW-1:0]    nc_m1;
  logic             coord_ok;
  logic             ram_we;
  logic [RW-1:0]    ram_wa, ram_ra;
  logic [MAX_COLUMNS-1:0] ram_wd, ram_rd, wmod, shift_row, next_row;
  logic [1:0]       vs [MAX_COLUMNS];

  // clamp sizes
  always_comb begin
    if (rows_r == 7'd0) nr = 7'd1;
    else if (32'(rows_r) > MAX_ROWS) nr = 7'(MAX_ROWS);
    else nr = rows_r;
    if (cols_r == 7'd0) nc = 7'd1;
    else if (32'(cols_r) > MAX_COLUMNS) nc = 7'(MAX_COLUMNS);
    else nc = cols_r;
  end
  assign nr_k     = KW'(nr);
  assign nc_m1    = CW'(nc - 7'd1);
  assign coord_ok = ({1'b0, in_item.row} < nr) && ({1'b0, in_item.column} < nc);

  // row memory
  lg_ram #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // column cells
  assign shift_row = (feed_k_r == nr_k + KW'(1)) ? row0_r : ram_rd;

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
    lg_nbr_t nbr;
    always_comb begin
      nbr.in_use = (32'(c) < 32'(nc));
      if (c == 0) nbr.left_sum = vs[nc_m1];
      else nbr.left_sum = vs[(c + MAX_COLUMNS - 1) % MAX_COLUMNS];
      if (CW'(c) == nc_m1) nbr.right_sum = vs[0];
      else nbr.right_sum = vs[(c + 1) % MAX_COLUMNS];
    end
    lg_cell u_cell (
      .clk      (clk),
      .shift_en (feed_v_r),
      .bit_in   (shift_row[c]),
      .nbr      (nbr),
      .vsum     (vs[c]),
      .next_bit (next_row[c])
    );
  end

  // cell update for write command
  always_comb begin
    wmod = ram_rd;
    wmod[col_r] = val_r;
  end

  // memory port selection
  always_comb begin
    ram_we = 1'b0;
    ram_wa = clr_r;
    ram_wd = '0;
    ram_ra = RW'(in_item.row);
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_RMW: begin
        ram_we = (cmd_r == CMD_WRITE);
        ram_wa = row_r;
        ram_wd = wmod;
      end
      ST_ADV: begin
        ram_we = win_v_r;
        ram_wa = RW'(win_k_r - KW'(2));
        ram_wd = next_row;
        ram_ra = (k_r == '0) ? RW'(nr - 7'd1) : RW'(k_r - KW'(1));
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    k_nxt         = k_r;
    feed_v_nxt    = 1'b0;
    feed_k_nxt    = feed_k_r;
    win_v_nxt     = 1'b0;
    win_k_nxt     = win_k_r;
    clr_nxt       = clr_r;
    clr_ack_nxt   = clr_ack_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + RW'(1);
        if (32'(clr_r) == MAX_ROWS - 1) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = clr_ack_r;
          out_nxt       = '{cell_value: 1'b0, generation: gen_r, applied: 1'b1};
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_nxt       = lg_cmd_t'(in_item.cmd);
          row_nxt       = RW'(in_item.row);
          col_nxt       = CW'(in_item.column);
          val_nxt       = in_item.value;
          out_valid_nxt = 1'b1;
          out_nxt       = '{cell_value: 1'b0, generation: gen_r, applied: 1'b0};
          case (in_item.cmd)
            CMD_WRITE, CMD_READ: begin
              if (coord_ok) begin
                state_nxt     = ST_RMW;
                out_valid_nxt = 1'b0;
              end
            end
            CMD_ADVANCE: begin
              if (run_r) begin
                state_nxt     = ST_ADV;
                k_nxt         = '0;
                out_valid_nxt = 1'b0;
              end
            end
            CMD_CLEAR: begin
              if (!run_r) begin
                state_nxt     = ST_CLEAR;
                clr_nxt       = '0;
                clr_ack_nxt   = 1'b1;
                out_valid_nxt = 1'b0;
              end
            end
            CMD_RST_GEN: begin
              gen_nxt = '0;
              out_nxt = '{cell_value: 1'b0, generation: 32'd0, applied: 1'b1};
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '{cell_value: (cmd_r == CMD_READ) ? ram_rd[col_r] : 1'b0,
                          generation: gen_r, applied: 1'b1};
      end
      ST_ADV: begin
        // issue row reads: wrap row, rows 0..nr-1, then the saved row 0
        if (k_r <= nr_k + KW'(1)) begin
          feed_v_nxt = 1'b1;
          feed_k_nxt = k_r;
          k_nxt      = k_r + KW'(1);
        end
        win_v_nxt = feed_v_r && (feed_k_r >= KW'(2));
        win_k_nxt = feed_k_r;
        if (win_v_r && (win_k_r == nr_k + KW'(1))) begin
          state_nxt     = ST_IDLE;
          gen_nxt       = gen_r + 32'd1;
          out_valid_nxt = 1'b1;
          out_nxt       = '{cell_value: 1'b0, generation: gen_r + 32'd1, applied: 1'b1};
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_ack_r   <= 1'b0;
      gen_r       <= '0;
      k_r         <= '0;
      feed_v_r    <= 1'b0;
      win_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= 7'd64;
      cols_r      <= 7'd64;
      run_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_ack_r   <= (state_nxt == ST_CLEAR) ? clr_ack_nxt : 1'b0;
      gen_r       <= gen_nxt;
      k_r         <= k_nxt;
      feed_v_r    <= feed_v_nxt;
      win_v_r     <= win_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS:    rows_r <= cfg_wdata;
          CFG_COLUMNS: cols_r <= cfg_wdata;
          CFG_RUNNING: run_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    feed_k_r <= feed_k_nxt;
    win_k_r  <= win_k_nxt;
    cmd_r    <= cmd_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    val_r    <= val_nxt;
    out_r    <= out_nxt;
    if (feed_v_r && (feed_k_r == KW'(1))) begin
      row0_r <= ram_rd;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import lg_pkg::*;

  localparam int MAX_R = 64;
  localparam int MAX_C = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  lg_in_t     in_item = '0;
  logic       busy;
  logic       out_valid;
  lg_out_t    out_result;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  life_grid_generation_step #(.MAX_ROWS(MAX_R), .MAX_COLUMNS(MAX_C)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .out_valid(out_valid), .out_result(out_result), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow grid and registers
  bit          grid [MAX_R][MAX_C];
  bit          grid_next [MAX_R][MAX_C];
  logic [31:0] gen_count;
  logic [6:0]  rows_reg, cols_reg;
  bit          run_reg;

  lg_in_t  cmd_queue [$];
  lg_out_t result_queue [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      cfg_req = 1'b0;

  function automatic int clamp_size(logic [6:0] v, int bound);
    if (v == 0) return 1;
    if (v > bound) return bound;
    return int'(v);
  endfunction

  function automatic void step_generation();
    int nr, nc, n, rr, cc;
    nr = clamp_size(rows_reg, MAX_R);
    nc = clamp_size(cols_reg, MAX_C);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = 0;
        for (int dr = 0; dr < 3; dr++) begin
          for (int dc = 0; dc < 3; dc++) begin
            if (dr == 1 && dc == 1) continue;
            rr = (r + dr + nr - 1) % nr;
            cc = (c + dc + nc - 1) % nc;
            n += grid[rr][cc];
          end
        end
        if (grid[r][c]) grid_next[r][c] = (n >= SURVIVE_LOW && n <= SURVIVE_HIGH);
        else grid_next[r][c] = (n == BIRTH_COUNT);
      end
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        grid[r][c] = grid_next[r][c];
    gen_count++;
  endfunction

  function automatic lg_out_t predict_command(lg_in_t it);
    lg_out_t res;
    bit in_range;
    res = '0;
    in_range = (it.row < clamp_size(rows_reg, MAX_R)) &&
               (it.column < clamp_size(cols_reg, MAX_C));
    case (it.cmd)
      CMD_WRITE: if (in_range) begin
        grid[it.row][it.column] = it.value;
        res.applied = 1'b1;
      end
      CMD_ADVANCE: if (run_reg) begin
        step_generation();
        res.applied = 1'b1;
      end
      CMD_READ: if (in_range) begin
        res.cell_value = grid[it.row][it.column];
        res.applied = 1'b1;
      end
      CMD_CLEAR: if (!run_reg) begin
        foreach (grid[r, c]) grid[r][c] = 1'b0;
        res.applied = 1'b1;
      end
      CMD_RST_GEN: begin
        gen_count = '0;
        res.applied = 1'b1;
      end
      default: ;
    endcase
    res.generation = gen_count;
    return res;
  endfunction

  // predict each accepted transaction
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      result_queue.push_back(predict_command(in_item));
    end
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        void'(cmd_queue.pop_front());
      end
      if ((start && busy) ) begin
        // hold the pending transaction
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0 && !cfg_req) begin
        in_item <= cmd_queue[0];
        start <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(12);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  lg_out_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (result_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_result);
        end else begin
          want = result_queue.pop_front();
          if (out_result.cell_value !== want.cell_value ||
              out_result.generation !== want.generation ||
              out_result.applied !== want.applied) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p actual %p", want, out_result);
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || result_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [6:0] val);
    wait_drained();
    cfg_req = 1'b1;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROWS:    rows_reg = val;
      CFG_COLUMNS: cols_reg = val;
      CFG_RUNNING: run_reg = val[0];
      default: ;
    endcase
    cfg_req = 1'b0;
  endtask

  function automatic lg_in_t make_cmd(logic [2:0] op, logic [5:0] r, logic [5:0] c,
                                      logic v);
    lg_in_t it;
    it.cmd = op;
    it.row = r;
    it.column = c;
    it.value = v;
    return it;
  endfunction

  // random command burst: writes, reads, advances, clears, count resets and unused codes
  task automatic random_phase(int nr, int nc, int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 45)
        cmd_queue.push_back(make_cmd(CMD_WRITE, 6'($urandom_range(nr)),
                                     6'($urandom_range(nc)), 1'($urandom_range(1))));
      else if (kind < 75)
        cmd_queue.push_back(make_cmd(CMD_READ, 6'($urandom_range(nr)),
                                     6'($urandom_range(nc)), 1'b0));
      else if (kind < 85)
        cmd_queue.push_back(make_cmd(CMD_ADVANCE, 6'($urandom), 6'($urandom),
                                     1'($urandom)));
      else if (kind < 90)
        cmd_queue.push_back(make_cmd(CMD_CLEAR, 6'($urandom), 6'($urandom),
                                     1'($urandom)));
      else if (kind < 94)
        cmd_queue.push_back(make_cmd(CMD_RST_GEN, 6'($urandom), 6'($urandom),
                                     1'($urandom)));
      else
        cmd_queue.push_back(make_cmd(3'($urandom_range(7, 5)), 6'($urandom),
                                     6'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    foreach (grid[r, c]) grid[r][c] = 1'b0;
    gen_count = '0;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    run_reg = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, corner cells on full grid
    cmd_queue.push_back(make_cmd(CMD_READ, 6'd63, 6'd63, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 6'd63, 6'd63, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 6'd0, 6'd0, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 6'd0, 6'd63, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_READ, 6'd63, 6'd63, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0));
    cmd_queue.push_back(make_cmd(3'd5, 6'd63, 6'd63, 1'b1));
    cmd_queue.push_back(make_cmd(3'd7, 6'd0, 6'd0, 1'b0));
    write_register(CFG_RUNNING, 7'd1);
    // corner cells wrap into a torus neighborhood
    cmd_queue.push_back(make_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_READ, 6'd63, 6'd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_CLEAR, 6'd0, 6'd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_RST_GEN, 6'd0, 6'd0, 1'b0));
    write_register(CFG_RUNNING, 7'd0);
    cmd_queue.push_back(make_cmd(CMD_CLEAR, 6'd0, 6'd0, 1'b0));
    // small sizes, out-of-range coordinates, zero and oversize registers
    write_register(CFG_ROWS, 7'd0);
    write_register(CFG_COLUMNS, 7'd2);
    cmd_queue.push_back(make_cmd(CMD_WRITE, 6'd0, 6'd1, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_WRITE, 6'd1, 6'd0, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_READ, 6'd0, 6'd2, 1'b0));
    write_register(CFG_RUNNING, 7'd1);
    cmd_queue.push_back(make_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_READ, 6'd0, 6'd1, 1'b0));
    write_register(CFG_ROWS, 7'd127);
    write_register(CFG_COLUMNS, 7'd100);
    cmd_queue.push_back(make_cmd(CMD_READ, 6'd0, 6'd1, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_ADVANCE, 6'd0, 6'd0, 1'b0));
    wait_drained();

    // random phases across sizes and run states
    write_register(CFG_ROWS, 7'd5);
    write_register(CFG_COLUMNS, 7'd6);
    write_register(CFG_RUNNING, 7'd0);
    random_phase(6, 7, 20);
    write_register(CFG_RUNNING, 7'd1);
    random_phase(6, 7, 25);
    write_register(CFG_ROWS, 7'd3);
    write_register(CFG_COLUMNS, 7'd1);
    random_phase(4, 2, 20);
    write_register(CFG_RUNNING, 7'd0);
    write_register(CFG_ROWS, 7'd64);
    write_register(CFG_COLUMNS, 7'd64);
    random_phase(63, 63, 20);
    write_register(CFG_RUNNING, 7'd1);
    write_register(CFG_ROWS, 7'd8);
    write_register(CFG_COLUMNS, 7'd8);
    random_phase(9, 9, 35);
    write_register(CFG_ROWS, 7'd64);
    write_register(CFG_COLUMNS, 7'd64);
    random_phase(63, 63, 10);
    wait_drained();
    repeat (80) @(posedge clk);

    if (mismatch_count == 0 && result_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/lg_pkg.sv
src/lg_ram.sv
src/lg_cell.sv
src/life_grid_generation_step.sv
sim/testbench.sv
